/* hdl/lppd_pkg.sv */
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types, codes and reset constants for the length-prefixed packet
// deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 255;
    localparam int BYTE_W            = 8;
    localparam int STATE_CODE_W      = 3;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'hFF;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] TRAILER_SECOND_RST = 8'h00;

    // Externally visible deframer state codes.
    localparam logic [STATE_CODE_W-1:0] PS_HDR1  = 3'd0;
    localparam logic [STATE_CODE_W-1:0] PS_HDR2  = 3'd1;
    localparam logic [STATE_CODE_W-1:0] PS_LEN   = 3'd2;
    localparam logic [STATE_CODE_W-1:0] PS_DATA  = 3'd3;
    localparam logic [STATE_CODE_W-1:0] PS_TAIL1 = 3'd4;
    localparam logic [STATE_CODE_W-1:0] PS_TAIL2 = 3'd5;

    typedef enum logic [1:0] {
        OP_RX    = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } opcode_e;

    typedef enum logic [1:0] {
        CFG_HEADER_FIRST   = 2'd0,
        CFG_HEADER_SECOND  = 2'd1,
        CFG_TRAILER_FIRST  = 2'd2,
        CFG_TRAILER_SECOND = 2'd3
    } cfg_idx_e;

    typedef enum logic [5:0] {
        ST_HDR1  = 6'b000001,
        ST_HDR2  = 6'b000010,
        ST_LEN   = 6'b000100,
        ST_DATA  = 6'b001000,
        ST_TAIL1 = 6'b010000,
        ST_TAIL2 = 6'b100000
    } state_e;

    typedef struct packed {
        opcode_e           opcode;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic                    frame_ready;
        logic [BYTE_W-1:0]       frame_length;
        logic [BYTE_W-1:0]       read_byte;
        logic [STATE_CODE_W-1:0] parse_state;
        logic                    framing_error;
    } result_t;

    typedef struct packed {
        cfg_idx_e          index;
        logic [BYTE_W-1:0] data;
    } cfg_t;

    // Per-item status from the parser to the result pipeline.
    typedef struct packed {
        logic                    frame_ready;
        logic [BYTE_W-1:0]       frame_length;
        logic [STATE_CODE_W-1:0] parse_state;
        logic                    framing_error;
        logic                    rd_en;
        logic                    rd_ok;
    } ctrl_t;

    // Payload store write request; index is the full payload position.
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] data;
    } wr_t;

    function automatic logic [STATE_CODE_W-1:0] state_code(input state_e st);
        logic [STATE_CODE_W-1:0] code;
        unique case (st)
            ST_HDR1:  code = PS_HDR1;
            ST_HDR2:  code = PS_HDR2;
            ST_LEN:   code = PS_LEN;
            ST_DATA:  code = PS_DATA;
            ST_TAIL1: code = PS_TAIL1;
            ST_TAIL2: code = PS_TAIL2;
            default:  code = PS_HDR1;
        endcase
        return code;
    endfunction

endpackage

/* hdl/lppd_chan_if.sv */
// ----------------------------------------------------------------------------
// lppd_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface lppd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/length_prefixed_packet_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer
// Header/length/payload/trailer deframer with a readable payload store.
// ----------------------------------------------------------------------------
// The block takes one item per clock on req unless a stalled rsp backs up
// the pipeline, and returns exactly one result item per input item on rsp,
// in order. An opcode of received byte advances the deframer (two
// header bytes, a length byte, that many payload bytes, two trailer bytes);
// read payload byte returns the stored byte at read_index; clear drops the
// frame ready flag. The payload bytes live in a synchronous RAM of
// PAYLOAD_DEPTH entries with a registered read: accepting an item updates
// the deframer registers, writes the RAM and launches the read, and the
// output register then takes that result and the read data for rsp. A payload
// byte written by one item is visible to a read in the very next item. The
// store is not cleared by reset; reading a position that no frame has written
// returns an undefined byte. Configuration writes on cfg are taken in any
// cycle and should be issued only while the block holds no items in flight.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer #(
    parameter int PAYLOAD_DEPTH = lppd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lppd_chan_if.sink          req,
    lppd_chan_if.source        rsp,
    lppd_chan_if.sink          cfg
);
    import lppd_pkg::*;

    localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

    // Parser outputs for the item being accepted this cycle.
    ctrl_t ctrl;
    wr_t   wr;
    item_t item;

    logic  accept;
    logic  s1_advance;

    // Stage 1 waits on the RAM read; the output register faces rsp.
    logic    s1_valid_reg;
    ctrl_t   s1_ctrl_reg;
    logic    out_valid_reg;
    result_t out_item_reg;

    logic [BYTE_W-1:0] ram_rdata;

    assign item = req.payload;

    // Stage 1 moves on whenever the output register is free or draining, so
    // a stalled rsp still lets one new item in before the input backs up.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign accept     = req.valid && req.ready;

    assign cfg.ready  = 1'b1;

    lppd_parser #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg.valid),
        .cfg_wr (cfg.payload),
        .accept (accept),
        .item   (item),
        .ctrl   (ctrl),
        .wr     (wr)
    );

    // The read data register only loads on an accepted read, so it stays
    // aligned with the item held in stage 1 while rsp is stalled.
    lppd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(PAYLOAD_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (accept && wr.en),
        .waddr (wr.index[ADDR_W-1:0]),
        .wdata (wr.data),
        .re    (accept && ctrl.rd_en),
        .raddr (item.read_index[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= ctrl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Reads of positions beyond the store, and all non-read items, show zero.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_item_reg.frame_ready   <= s1_ctrl_reg.frame_ready;
            out_item_reg.frame_length  <= s1_ctrl_reg.frame_length;
            out_item_reg.parse_state   <= s1_ctrl_reg.parse_state;
            out_item_reg.framing_error <= s1_ctrl_reg.framing_error;
            out_item_reg.read_byte     <= (s1_ctrl_reg.rd_en && s1_ctrl_reg.rd_ok)
                                          ? ram_rdata : '0;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    // A framing error always leaves an empty, unready deframer at the start.
    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.framing_error |->
            (rsp.payload.parse_state == PS_HDR1) && !rsp.payload.frame_ready &&
            (rsp.payload.frame_length == '0))
        else $error("framing error result does not show a cleared deframer");

    // One item never both writes and reads the payload store.
    a_no_rw_same_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(wr.en && ctrl.rd_en))
        else $error("payload store written and read by the same item");

    // With both stages full and rsp stalled, no further item may enter.
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("item accepted while the pipeline is full");

    // A held result must not change while it waits on rsp. The read data
    // only matters for an in-range read.
    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_ctrl_reg)
            && (!(s1_ctrl_reg.rd_en && s1_ctrl_reg.rd_ok) || $stable(ram_rdata)))
        else $error("stalled stage 1 item changed");
endmodule

/* hdl/lppd_ram.sv */
// ----------------------------------------------------------------------------
// lppd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lppd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hdl/lppd_parser.sv */
// ----------------------------------------------------------------------------
// lppd_parser
// Deframer state machine, frame bookkeeping and configuration registers.
// ----------------------------------------------------------------------------
module lppd_parser #(
    parameter int PAYLOAD_DEPTH = lppd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  lppd_pkg::cfg_t  cfg_wr,
    input  logic            accept,
    input  lppd_pkg::item_t item,
    output lppd_pkg::ctrl_t ctrl,
    output lppd_pkg::wr_t   wr
);
    import lppd_pkg::*;

    localparam logic [BYTE_W-1:0] DEPTH_LIM = BYTE_W'(PAYLOAD_DEPTH);

    state_e            state_reg,  state_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] count_reg,  count_next;
    logic              ready_reg,  ready_next;
    logic              err;
    logic [BYTE_W-1:0] count_inc;

    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] trailer_first_reg;
    logic [BYTE_W-1:0] trailer_second_reg;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        count_next  = count_reg;
        ready_next  = ready_reg;
        err         = 1'b0;
        wr.en       = 1'b0;
        wr.index    = count_reg;
        wr.data     = item.rx_byte;

        unique case (item.opcode)
            OP_RX:
            begin
                unique case (state_reg)
                    ST_HDR1:
                    begin
                        if (item.rx_byte == header_first_reg)
                        begin
                            state_next = ST_HDR2;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    ST_HDR2:
                    begin
                        if (item.rx_byte == header_second_reg)
                        begin
                            state_next = ST_LEN;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    ST_LEN:
                    begin
                        length_next = item.rx_byte;
                        count_next  = '0;
                        // An empty payload skips straight to the trailer.
                        state_next  = (item.rx_byte == '0) ? ST_TAIL1 : ST_DATA;
                    end
                    ST_DATA:
                    begin
                        // Bytes past the store are counted but dropped.
                        wr.en      = (count_reg < DEPTH_LIM);
                        count_next = count_inc;
                        if (count_inc == length_reg)
                        begin
                            state_next = ST_TAIL1;
                        end
                    end
                    ST_TAIL1:
                    begin
                        if (item.rx_byte == trailer_first_reg)
                        begin
                            state_next = ST_TAIL2;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    ST_TAIL2:
                    begin
                        if (item.rx_byte == trailer_second_reg)
                        begin
                            ready_next = 1'b1;
                            state_next = ST_HDR1;
                            count_next = '0;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                // Any header or trailer mismatch drops the whole frame.
                if (err)
                begin
                    state_next  = ST_HDR1;
                    length_next = '0;
                    count_next  = '0;
                    ready_next  = 1'b0;
                end
            end
            OP_CLEAR:
            begin
                ready_next = 1'b0;
            end
            OP_READ, OP_NONE:
            begin
            end
        endcase
    end

    always_comb
    begin
        ctrl.frame_ready   = ready_next;
        ctrl.frame_length  = length_next;
        ctrl.parse_state   = state_code(state_next);
        ctrl.framing_error = err;
        ctrl.rd_en         = (item.opcode == OP_READ);
        ctrl.rd_ok         = (item.read_index < DEPTH_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_HDR1;
            length_reg <= '0;
            count_reg  <= '0;
            ready_reg  <= 1'b0;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            ready_reg  <= ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg   <= HEADER_FIRST_RST;
            header_second_reg  <= HEADER_SECOND_RST;
            trailer_first_reg  <= TRAILER_FIRST_RST;
            trailer_second_reg <= TRAILER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_wr.index)
                CFG_HEADER_FIRST:   header_first_reg   <= cfg_wr.data;
                CFG_HEADER_SECOND:  header_second_reg  <= cfg_wr.data;
                CFG_TRAILER_FIRST:  trailer_first_reg  <= cfg_wr.data;
                CFG_TRAILER_SECOND: trailer_second_reg <= cfg_wr.data;
            endcase
        end
    end
endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed packet deframer. Received
// bytes, payload reads, flag clears and the unused opcode go in through the
// request channel in random bursts. Every result that comes back is checked
// field by field against an in-bench prediction of the deframer, while the
// result channel is stalled on a pattern of its own.
// ----------------------------------------------------------------------------
module testbench;
    import lppd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_DEPTH          = PAYLOAD_DEPTH_DEF;
    localparam int RANDOM_ITEMS_PER_PHASE = 210;
    localparam int CONFIG_PHASES          = 5;
    localparam int SETTLE_CYCLES          = 4;
    localparam int TAIL_CYCLES            = 20;
    localparam int IDLE_LIMIT             = 4000;
    localparam int MAX_PRINTED_ERRORS     = 40;

    // Ways in which a generated frame can be broken on purpose.
    typedef enum int {
        FLAW_NONE,
        FLAW_HEADER,
        FLAW_TRAILER_FIRST,
        FLAW_TRAILER_SECOND
    } frame_flaw_e;

    // Everything the deframer keeps between items. The span is the number of
    // store entries written so far; frames always write from position zero
    // upward, so the written entries form one run from the bottom.
    typedef struct {
        logic [STATE_CODE_W-1:0] state;
        logic [BYTE_W-1:0]       length;
        logic [BYTE_W-1:0]       count;
        logic                    ready;
        logic [BYTE_W-1:0]       store [PAYLOAD_DEPTH];
        int                      span;
    } deframer_t;

    logic clk;
    logic rst_n;

    lppd_chan_if #(.T(item_t))   req_if ();
    lppd_chan_if #(.T(result_t)) rsp_if ();
    lppd_chan_if #(.T(cfg_t))    cfg_if ();

    length_prefixed_packet_deframer #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Register values as the block holds them. Both deframer copies below
    // read them; they only change while nothing is in flight.
    logic [BYTE_W-1:0] cfg_regs [4];

    // The planned copy runs as items are generated, so that stimulus can
    // follow the deframer (resync, reads of written entries only). The
    // predicted copy runs as the block accepts items and feeds the checker.
    deframer_t planned_deframer;
    deframer_t predicted_deframer;

    item_t   outgoing_items [$];
    result_t predicted_results [$];

    int error_count = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic void reset_deframer(ref deframer_t m);
        m.state  = PS_HDR1;
        m.length = '0;
        m.count  = '0;
        m.ready  = 1'b0;
        m.span   = 0;
        foreach (m.store[i]) m.store[i] = '0;
    endfunction

    // Applies one item to a deframer copy and returns the result it causes.
    function automatic result_t advance_deframer(ref deframer_t m, input item_t it);
        result_t r;
        logic    bad;
        r   = '0;
        bad = 1'b0;
        case (it.opcode)
            OP_RX:
            begin
                case (m.state)
                    PS_HDR1:
                        if (it.rx_byte == cfg_regs[CFG_HEADER_FIRST]) m.state = PS_HDR2;
                        else bad = 1'b1;
                    PS_HDR2:
                        if (it.rx_byte == cfg_regs[CFG_HEADER_SECOND]) m.state = PS_LEN;
                        else bad = 1'b1;
                    PS_LEN:
                    begin
                        m.length = it.rx_byte;
                        m.count  = '0;
                        m.state  = (it.rx_byte == '0) ? PS_TAIL1 : PS_DATA;
                    end
                    PS_DATA:
                    begin
                        // Bytes past the end of the store are counted but dropped.
                        if (int'(m.count) < PAYLOAD_DEPTH)
                        begin
                            m.store[m.count] = it.rx_byte;
                            if (int'(m.count) >= m.span) m.span = int'(m.count) + 1;
                        end
                        m.count = m.count + 8'd1;
                        if (m.count == m.length) m.state = PS_TAIL1;
                    end
                    PS_TAIL1:
                        if (it.rx_byte == cfg_regs[CFG_TRAILER_FIRST]) m.state = PS_TAIL2;
                        else bad = 1'b1;
                    PS_TAIL2:
                        if (it.rx_byte == cfg_regs[CFG_TRAILER_SECOND])
                        begin
                            m.ready = 1'b1;
                            m.state = PS_HDR1;
                            m.count = '0;
                        end
                        else bad = 1'b1;
                    default: ;
                endcase
                // Any mismatch drops the whole frame, flag included, and the
                // offending byte is not looked at again.
                if (bad)
                begin
                    m.state  = PS_HDR1;
                    m.length = '0;
                    m.count  = '0;
                    m.ready  = 1'b0;
                end
            end
            OP_READ:
                if (int'(it.read_index) < PAYLOAD_DEPTH) r.read_byte = m.store[it.read_index];
            OP_CLEAR:
                m.ready = 1'b0;
            default: ;
        endcase
        r.frame_ready   = m.ready;
        r.frame_length  = m.length;
        r.parse_state   = m.state;
        r.framing_error = bad;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every item goes through the planned deframer as it is
    // queued. Fields that an opcode ignores carry random values.
    // ------------------------------------------------------------------------

    task automatic queue_item(input opcode_e op, input logic [7:0] b, input logic [7:0] idx);
        item_t   it;
        result_t unused;
        it.opcode     = op;
        it.rx_byte    = b;
        it.read_index = idx;
        outgoing_items.push_back(it);
        unused = advance_deframer(planned_deframer, it);
    endtask

    task automatic queue_rx(input logic [7:0] b);
        queue_item(OP_RX, b, 8'($urandom));
    endtask

    task automatic queue_read(input logic [7:0] idx);
        queue_item(OP_READ, 8'($urandom), idx);
    endtask

    task automatic queue_plain(input opcode_e op);
        queue_item(op, 8'($urandom), 8'($urandom));
    endtask

    // A byte that surely differs from the one given.
    function automatic logic [7:0] wrong_byte(input logic [7:0] b);
        return b ^ 8'($urandom_range(255, 1));
    endfunction

    // This picks only positions that some frame has written.
    function automatic logic [7:0] pick_read_index();
        int hi;
        hi = planned_deframer.span - 1;
        case ($urandom_range(3, 0))
            0:       return 8'd0;
            1:       return 8'(hi);
            default: return 8'($urandom_range(hi, 0));
        endcase
    endfunction

    // A read, a clear or the unused opcode; reads only once something is stored.
    task automatic queue_side_item();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick < 6 && planned_deframer.span > 0) queue_read(pick_read_index());
        else if (pick < 8) queue_plain(OP_CLEAR);
        else queue_plain(OP_NONE);
    endtask

    // Random bytes, half of them copies of the framing bytes so that noise
    // now and then wanders into the later states.
    task automatic queue_noise();
        int n;
        n = $urandom_range(6, 1);
        repeat (n)
        begin
            if ($urandom_range(1, 0) == 0) queue_rx(8'($urandom));
            else queue_rx(cfg_regs[$urandom_range(3, 0)]);
        end
    endtask

    // Brings the planned deframer back to the first header state: payload
    // positions are filled, and a framing byte is answered with a wrong one.
    task automatic queue_resync();
        while (planned_deframer.state != PS_HDR1)
        begin
            case (planned_deframer.state)
                PS_HDR2:  queue_rx(wrong_byte(cfg_regs[CFG_HEADER_SECOND]));
                PS_LEN:   queue_rx(8'd1);
                PS_TAIL1: queue_rx(wrong_byte(cfg_regs[CFG_TRAILER_FIRST]));
                PS_TAIL2: queue_rx(wrong_byte(cfg_regs[CFG_TRAILER_SECOND]));
                default:  queue_rx(8'($urandom));
            endcase
        end
    endtask

    task automatic queue_frame(input int len, input frame_flaw_e flaw);
        queue_resync();
        queue_rx(cfg_regs[CFG_HEADER_FIRST]);
        if (flaw == FLAW_HEADER)
        begin
            queue_rx(wrong_byte(cfg_regs[CFG_HEADER_SECOND]));
            return;
        end
        queue_rx(cfg_regs[CFG_HEADER_SECOND]);
        queue_rx(8'(len));
        for (int i = 0; i < len; i++)
        begin
            queue_rx(8'($urandom));
            // Reads and clears in the middle of a frame must not disturb it.
            if ($urandom_range(99, 0) < 6) queue_side_item();
        end
        if (flaw == FLAW_TRAILER_FIRST) queue_rx(wrong_byte(cfg_regs[CFG_TRAILER_FIRST]));
        else queue_rx(cfg_regs[CFG_TRAILER_FIRST]);
        if (flaw == FLAW_TRAILER_SECOND) queue_rx(wrong_byte(cfg_regs[CFG_TRAILER_SECOND]));
        else if (flaw == FLAW_NONE) queue_rx(cfg_regs[CFG_TRAILER_SECOND]);
    endtask

    // Mostly short frames; the store is filled to the top by a forced frame
    // of the largest length instead of random ones.
    function automatic int pick_frame_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 10) return 0;
        else if (r < 80) return $urandom_range(8, 1);
        else if (r < 98) return $urandom_range(48, 9);
        else return $urandom_range(120, 49);
    endfunction

    function automatic frame_flaw_e pick_frame_flaw();
        int r;
        r = $urandom_range(99, 0);
        if (r < 79) return FLAW_NONE;
        else if (r < 86) return FLAW_HEADER;
        else if (r < 93) return FLAW_TRAILER_FIRST;
        else return FLAW_TRAILER_SECOND;
    endfunction

    // Register writes go out one at a time on the configuration channel.
    task automatic write_reg(input cfg_idx_e idx, input logic [7:0] value);
        @(posedge clk);
        cfg_if.valid         <= 1'b1;
        cfg_if.payload.index <= idx;
        cfg_if.payload.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        cfg_regs[idx] = value;
    endtask

    // Holds the sender off until every queued item has been answered. The
    // check runs on the falling edge so that all updates of the rising edge
    // have settled.
    task automatic wait_for_drain();
        @(negedge clk);
        while (outgoing_items.size() != 0 || req_if.valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED_ERRORS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and known values on every input from time zero.
    // ------------------------------------------------------------------------

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver. Items leave the outgoing queue in bursts of random
    // length with random gaps between them. The predicted deframer advances
    // on the edge at which the block accepts an item. Valid is written once
    // per edge, so back-to-back items keep it high without a glitch.
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        item_t next_item;
        logic  next_valid;
        if (!rst_n)
        begin
            req_if.valid   <= 1'b0;
            req_if.payload <= '0;
        end
        else
        begin
            next_item  = req_if.payload;
            next_valid = req_if.valid;
            if (req_if.valid && req_if.ready)
            begin
                predicted_results.push_back(
                    advance_deframer(predicted_deframer, req_if.payload));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0) gap_left--;
                else if (outgoing_items.size() != 0)
                begin
                    next_item  = outgoing_items.pop_front();
                    next_valid = 1'b1;
                    if (burst_left == 0) burst_left = $urandom_range(40, 1);
                    burst_left--;
                    // At the end of a burst: sometimes no gap, mostly a short
                    // one, now and then a long one.
                    if (burst_left == 0)
                    begin
                        case ($urandom_range(9, 0))
                            0, 1:    gap_left = 0;
                            8, 9:    gap_left = $urandom_range(24, 8);
                            default: gap_left = $urandom_range(4, 1);
                        endcase
                    end
                end
            end
            req_if.valid   <= next_valid;
            req_if.payload <= next_item;
        end
    end

    // ------------------------------------------------------------------------
    // Result side backpressure. Each time the stall phase wraps, a fresh stall
    // pattern is drawn: no stalls at all, heavy stalling, or an even mix.
    // ------------------------------------------------------------------------

    logic [31:0] stall_pattern = '1;
    int          stall_phase   = 0;

    always @(posedge clk or negedge rst_n)
    begin : drive_backpressure
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (stall_phase == 0)
            begin
                case ($urandom_range(3, 0))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom & $urandom;
                    default: stall_pattern = $urandom;
                endcase
            end
            rsp_if.ready <= stall_pattern[stall_phase];
            stall_phase = (stall_phase + 1) % 32;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: each accepted result is held against the oldest
    // prediction, one field at a time.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.payload;
            if (predicted_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no item outstanding", got));
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("frame_ready", 8'(got.frame_ready), 8'(want.frame_ready));
                check_field("frame_length", got.frame_length, want.frame_length);
                check_field("read_byte", got.read_byte, want.read_byte);
                check_field("parse_state", 8'(got.parse_state), 8'(want.parse_state));
                check_field("framing_error", 8'(got.framing_error), 8'(want.framing_error));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch with no handshake on any channel means the
    // block has hung.
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence. A directed part runs on the reset register values, then
    // each phase writes all four registers while the block is idle and sends
    // a random mix of frames, reads, clears and noise.
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        logic [7:0] setting [4];
        logic [7:0] hf;
        logic [7:0] hs;
        logic [7:0] tf;
        logic [7:0] ts;
        int         target;
        int         pick;

        cfg_regs[CFG_HEADER_FIRST]   = HEADER_FIRST_RST;
        cfg_regs[CFG_HEADER_SECOND]  = HEADER_SECOND_RST;
        cfg_regs[CFG_TRAILER_FIRST]  = TRAILER_FIRST_RST;
        cfg_regs[CFG_TRAILER_SECOND] = TRAILER_SECOND_RST;
        reset_deframer(planned_deframer);
        reset_deframer(predicted_deframer);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        hf = cfg_regs[CFG_HEADER_FIRST];
        hs = cfg_regs[CFG_HEADER_SECOND];
        tf = cfg_regs[CFG_TRAILER_FIRST];
        ts = cfg_regs[CFG_TRAILER_SECOND];

        // A good two-byte frame with extreme payload values, and a read and a
        // clear slipped in between the payload bytes.
        queue_rx(hf);
        queue_rx(hs);
        queue_rx(8'd2);
        queue_rx(8'h00);
        queue_read(8'd0);
        queue_plain(OP_CLEAR);
        queue_rx(8'hFF);
        queue_rx(tf);
        queue_rx(ts);
        // Read back the first byte and the position just past the store,
        // which reads as zero; the unused opcode only reports the state.
        queue_read(8'd0);
        queue_read(8'(PAYLOAD_DEPTH));
        queue_plain(OP_NONE);
        // A zero length goes straight to the trailer.
        queue_rx(hf);
        queue_rx(hs);
        queue_rx(8'd0);
        queue_rx(tf);
        queue_rx(ts);
        // A wrong first header byte, then a wrong second header byte.
        queue_rx(wrong_byte(hf));
        queue_rx(hf);
        queue_rx(wrong_byte(hs));
        // Wrong first trailer byte, then wrong second trailer byte.
        queue_rx(hf);
        queue_rx(hs);
        queue_rx(8'd0);
        queue_rx(wrong_byte(tf));
        queue_rx(hf);
        queue_rx(hs);
        queue_rx(8'd0);
        queue_rx(tf);
        queue_rx(wrong_byte(ts));
        wait_for_drain();

        for (int ph = 1; ph <= CONFIG_PHASES; ph++)
        begin
            // Phase one uses all zeros, phase two all ones, the last one goes
            // back to the reset values, the rest are random.
            for (int r = 0; r < 4; r++)
            begin
                case (ph)
                    1:       setting[r] = 8'h00;
                    2:       setting[r] = 8'hFF;
                    default: setting[r] = 8'($urandom);
                endcase
            end
            if (ph == CONFIG_PHASES)
            begin
                setting[CFG_HEADER_FIRST]   = HEADER_FIRST_RST;
                setting[CFG_HEADER_SECOND]  = HEADER_SECOND_RST;
                setting[CFG_TRAILER_FIRST]  = TRAILER_FIRST_RST;
                setting[CFG_TRAILER_SECOND] = TRAILER_SECOND_RST;
            end
            for (int r = 0; r < 4; r++) write_reg(cfg_idx_e'(r), setting[r]);

            // One frame of the largest length fills the whole store, so that
            // reads can reach every position from then on.
            if (ph == 1) queue_frame(255, FLAW_NONE);

            target = outgoing_items.size() + RANDOM_ITEMS_PER_PHASE;
            while (outgoing_items.size() < target)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 65)
                begin
                    queue_frame(pick_frame_length(), pick_frame_flaw());
                    if ($urandom_range(9, 0) < 4)
                        repeat ($urandom_range(3, 1)) queue_side_item();
                end
                else if (pick < 85)
                begin
                    repeat ($urandom_range(4, 1)) queue_side_item();
                end
                else
                begin
                    queue_noise();
                end
            end
            wait_for_drain();
        end

        // Anything that still comes out now has no item behind it.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
